// ----- sv/lpe_pkg.sv -----
// ----------------------------------------------------------------------------
// lpe_pkg: shared constants for the Legendre polynomial evaluator
// Field widths, Q2.30 constants and the default degree limit.
// ----------------------------------------------------------------------------
package lpe_pkg;

  localparam int DEGREE_W       = 7;
  localparam int POINT_W        = 32;
  localparam int VALUE_W        = 32;
  localparam int MAX_DEGREE_DEF = 64;

  // Q2.30 constants
  localparam int signed ONE_Q30  = 32'sd1073741824;
  localparam int signed HALF_Q30 = 32'sd536870912;

endpackage

// ----- sv/lpe_if.sv -----
// ----------------------------------------------------------------------------
// lpe_in_if / lpe_out_if: valid/ready channels of the polynomial evaluator
// One input item carries degree and point; one result item carries value.
// ----------------------------------------------------------------------------
interface lpe_in_if;
  logic                                valid;
  logic                                ready;
  logic        [lpe_pkg::DEGREE_W-1:0] degree;
  logic signed [lpe_pkg::POINT_W-1:0]  point;

  modport source (output valid, output degree, output point, input ready);
  modport sink   (input valid, input degree, input point, output ready);
endinterface

interface lpe_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [lpe_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ----- sv/legendre_poly_eval.sv -----
// ----------------------------------------------------------------------------
// legendre_poly_eval: Legendre polynomial P_n(x) in Q2.30
// Three-term recurrence on one shared 33x33 signed multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : item = {degree, point}. point is Q2.30 and clamped to [-1,1],
//            degree saturates at MAX_DEGREE.
//   out_ch : item = {value}, P_n(x) in Q2.30, saturated to [-1,1].
//   in_ch.ready is high only while the sequencer is idle; one item is
//   worked on at a time.
// Sequence: degree 0 or 1 goes from idle straight to S_OUT; degree n >= 2
//   runs the recurrence for k = 2 to n, each step through XP, C2, C1, NUM, LO, HI, FIN:
//   five passes through the shared multiplier (x*P1, (k-1)*P2, (2k-1)*t and
//   the two halves of num*R(k)), one subtract and one round/clamp.
//   The next item is accepted the cycle after the result is loaded into the
//   output register; no new item is taken while one is in progress.
// Stall: the result sits in an output register until taken; a new item is
//   accepted while it waits, but its own result is held back until the
//   register is free.
// Reset: rst (synchronous) returns the sequencer to idle and drops
//   out_ch.valid; any item in progress is lost.
// ----------------------------------------------------------------------------
module legendre_poly_eval #(
  parameter int MAX_DEGREE = lpe_pkg::MAX_DEGREE_DEF
) (
  input  logic      clk,
  input  logic      rst,
  lpe_in_if.sink    in_ch,
  lpe_out_if.source out_ch
);

  // degree port is 7 bits, so the recurrence never runs past 127
  localparam int DEG_LIM = (1 << lpe_pkg::DEGREE_W) - 1;
  localparam int KMAX    = (MAX_DEGREE < DEG_LIM) ? MAX_DEGREE : DEG_LIM;
  localparam int KW      = $clog2(KMAX + 1);
  localparam int CW      = KW + 1;
  localparam int NW      = 32 + KW + 2;     // num = (2k-1)*t - (k-1)*P2
  localparam int SPLIT   = 24;              // low slice of num for num*R
  localparam int MW      = 66;              // multiplier product
  localparam int LPW     = SPLIT + 31;      // low partial product
  localparam int SW      = NW + 32;         // full num*R
  localparam int RW      = SW - 30;         // num*R after rounding

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_XP   = 4'd1;
  localparam logic [3:0] S_C2   = 4'd2;
  localparam logic [3:0] S_C1   = 4'd3;
  localparam logic [3:0] S_NUM  = 4'd4;
  localparam logic [3:0] S_LO   = 4'd5;
  localparam logic [3:0] S_HI   = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  // reciprocal table R(k) = round(2^30 / k)
  logic [31:0] recip_tbl [KMAX+1];

  for (genvar g = 0; g <= KMAX; g++) begin : g_recip
    localparam longint RK = (g == 0) ? 64'd0 : ((((64'd1 << 31) / g) + 64'd1) >> 1);
    assign recip_tbl[g] = RK[31:0];
  end

  logic [3:0]               state;
  logic [KW-1:0]            k;
  logic [KW-1:0]            n;
  logic signed [31:0]       x;
  logic signed [31:0]       p1;
  logic signed [31:0]       p2;
  logic signed [31:0]       t;
  logic signed [MW-1:0]     prod;
  logic signed [NW-1:0]     hold;
  logic signed [NW-1:0]     num;
  logic [LPW-1:0]           lo_prod;
  logic                     out_valid;
  logic signed [31:0]       out_value;

  logic signed [32:0]       mul_a;
  logic signed [32:0]       mul_b;
  logic signed [MW-1:0]     mul_p;
  logic [CW-1:0]            coef1;
  logic [KW-1:0]            coef2;
  logic [31:0]              recip;
  logic signed [31:0]       x_clamp;
  logic [KW-1:0]            n_sat;
  logic signed [MW-1:0]     t_adj;
  logic signed [MW-1:0]     t_shr;
  logic signed [SW-1:0]     sum;
  logic signed [SW-1:0]     sum_adj;
  logic signed [SW-1:0]     sum_shr;
  logic signed [RW-1:0]     rv;
  logic signed [31:0]       p_new;
  logic                     out_free;

  assign coef1 = {k, 1'b0} - CW'(1);
  assign coef2 = k - KW'(1);
  assign recip = recip_tbl[k];

  // input clamp and degree saturation
  always_comb begin
    if (in_ch.point > 32'(lpe_pkg::ONE_Q30)) begin
      x_clamp = 32'(lpe_pkg::ONE_Q30);
    end else if (in_ch.point < -32'(lpe_pkg::ONE_Q30)) begin
      x_clamp = -32'(lpe_pkg::ONE_Q30);
    end else begin
      x_clamp = in_ch.point;
    end
    if (32'(in_ch.degree) > 32'(KMAX)) begin
      n_sat = KW'(KMAX);
    end else begin
      n_sat = KW'(in_ch.degree);
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (state)
      S_XP: begin
        mul_a = 33'(x);
        mul_b = 33'(p1);
      end
      S_C2: begin
        mul_a = 33'(p2);
        mul_b = signed'(33'(coef2));
      end
      S_C1: begin
        mul_a = 33'(t);
        mul_b = signed'(33'(coef1));
      end
      S_LO: begin
        mul_a = signed'(33'(num[SPLIT-1:0]));
        mul_b = signed'(33'(recip));
      end
      S_HI: begin
        mul_a = 33'(signed'(num[NW-1:SPLIT]));
        mul_b = signed'(33'(recip));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // round to nearest, ties away from zero: (v + half - (v<0)) >>> 30; clamp to [-1,1]
  always_comb begin
    if (prod[MW-1]) begin
      t_adj = prod + MW'(lpe_pkg::HALF_Q30) - MW'(1);
    end else begin
      t_adj = prod + MW'(lpe_pkg::HALF_Q30);
    end
    t_shr = t_adj >>> 30;

    sum = (SW'(prod) <<< SPLIT) + SW'(signed'({1'b0, lo_prod}));
    if (sum[SW-1]) begin
      sum_adj = sum + SW'(lpe_pkg::HALF_Q30) - SW'(1);
    end else begin
      sum_adj = sum + SW'(lpe_pkg::HALF_Q30);
    end
    sum_shr = sum_adj >>> 30;
    rv      = sum_shr[RW-1:0];

    if (rv > RW'(lpe_pkg::ONE_Q30)) begin
      p_new = 32'(lpe_pkg::ONE_Q30);
    end else if (rv < -RW'(lpe_pkg::ONE_Q30)) begin
      p_new = -32'(lpe_pkg::ONE_Q30);
    end else begin
      p_new = signed'(rv[31:0]);
    end
  end

  assign out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            state <= (n_sat < KW'(2)) ? S_OUT : S_XP;
          end
        end
        S_XP:  state <= S_C2;
        S_C2:  state <= S_C1;
        S_C1:  state <= S_NUM;
        S_NUM: state <= S_LO;
        S_LO:  state <= S_HI;
        S_HI:  state <= S_FIN;
        S_FIN: state <= (k == n) ? S_OUT : S_XP;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        x  <= x_clamp;
        n  <= n_sat;
        k  <= KW'(2);
        p2 <= 32'(lpe_pkg::ONE_Q30);
        p1 <= (n_sat == '0) ? 32'(lpe_pkg::ONE_Q30) : x_clamp;
      end
      S_XP: prod <= mul_p;
      S_C2: begin
        t    <= t_shr[31:0];
        prod <= mul_p;
      end
      S_C1: begin
        hold <= prod[NW-1:0];
        prod <= mul_p;
      end
      S_NUM: num <= prod[NW-1:0] - hold;
      S_LO:  prod <= mul_p;
      S_HI: begin
        lo_prod <= prod[LPW-1:0];
        prod    <= mul_p;
      end
      S_FIN: begin
        p2 <= p1;
        p1 <= p_new;
        k  <= k + KW'(1);
      end
      S_OUT: begin
        if (out_free) begin
          out_value <= p1;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.value = out_value;

endmodule

// ----- sv/lpe_check.sv -----
// ----------------------------------------------------------------------------
// lpe_check: port-level checks for legendre_poly_eval
// Watches both channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
module lpe_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic        [lpe_pkg::DEGREE_W-1:0] in_degree,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [lpe_pkg::VALUE_W-1:0] out_value
);

  // held result must not change or vanish while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result item changed while stalled");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_value <= lpe_pkg::ONE_Q30) && (out_value >= -lpe_pkg::ONE_Q30))
    else $error("result outside [-1,1]");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // degree zero gives exactly one via S_OUT and the output register, when output is free
  a_deg0: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_degree == '0) && (!out_valid || out_ready)
    |=> ##1 (out_valid && (out_value == lpe_pkg::ONE_Q30)))
    else $error("degree zero result wrong");

endmodule

bind legendre_poly_eval lpe_check u_lpe_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_degree (in_ch.degree),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value)
);
